// ----- rtl/mmt_pkg.sv -----
// mmt_pkg: shared types and codes of the multiset mex tracker
// no dependencies; compiled first

package mmt_pkg;

	// fixed payload widths
	localparam int VALUE_W    = 12;
	localparam int MEX_W      = 13;
	localparam int STATUS_W   = 2;
	// number of distinct values an item can name
	localparam int VALUE_SPAN = 4096;
	// fixed-point shift of the reciprocal used to split a value into leaf and bit
	localparam int DIV_SHIFT  = 24;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_ERASE  = 1'b1;

	typedef logic [STATUS_W-1:0] status_t;

	// status codes
	localparam status_t ST_APPLIED = 2'd0;
	localparam status_t ST_ABSENT  = 2'd1;
	localparam status_t ST_CEILING = 2'd2;

	typedef enum logic [2:0] {
		MMT_CLEAR,
		MMT_IDLE,
		MMT_DIV,
		MMT_READ,
		MMT_MODIFY,
		MMT_SCAN,
		MMT_LEAF,
		MMT_DONE
	} mmt_state_t;

endpackage

// ----- rtl/mmt_item_if.sv -----
// mmt_item_if: input channel of the mex tracker (insert or erase one value)
// depends on mmt_pkg

interface mmt_item_if;
	import mmt_pkg::*;

	logic               valid;
	logic               ready;
	logic               operation;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

// ----- rtl/mmt_result_if.sv -----
// mmt_result_if: result channel of the mex tracker (mex and status)
// depends on mmt_pkg

interface mmt_result_if;
	import mmt_pkg::*;

	logic             valid;
	logic             ready;
	logic [MEX_W-1:0] mex;
	status_t          status;

	modport source (output valid, output mex, output status, input ready);
	modport sink   (input valid, input mex, input status, output ready);
endinterface

// ----- rtl/mmt_ram.sv -----
// mmt_ram: generic single-write, single-read ram with registered read data
// no dependencies

module mmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/multiset_mex_tracker.sv -----
// multiset_mex_tracker: multiset of small integers that reports its mex after each update
// depends on mmt_pkg, mmt_item_if, mmt_result_if, mmt_ram
// sequence: an item taken in IDLE passes DIV, READ, MODIFY, SCAN (one summary word per step,
//   up to the first that shows a hole), LEAF and DONE; LEAF is left out when no word shows
//   a hole, READ and MODIFY for a value at or past CAPACITY; one item in flight at a time,
//   and a stalled result holds the next item in its last step
// reset: arst_n clears control at once, then a clearing pass over min(CAPACITY, 4096) entries
//   zeroes the count ram and refills the leaf ram; no input transfer meanwhile

module multiset_mex_tracker #(
	parameter int CAPACITY   = 4096,
	parameter int WORD_BITS  = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mmt_item_if.sink     item,
	mmt_result_if.source result
);
	import mmt_pkg::*;

	// values above the item range can never be inserted and are always absent,
	// so only the reachable part of the value space is stored
	localparam int TRACKED  = (CAPACITY < VALUE_SPAN) ? CAPACITY : VALUE_SPAN;
	localparam int LEAVES   = (TRACKED + WORD_BITS - 1) / WORD_BITS;
	localparam int SWORDS   = (LEAVES + WORD_BITS - 1) / WORD_BITS;
	localparam int SUM_BITS = SWORDS * WORD_BITS;
	localparam int CNT_AW   = $clog2(TRACKED);
	localparam int LEAF_AW  = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int BIT_AW   = $clog2(WORD_BITS);
	localparam int SUM_AW   = $clog2(SUM_BITS);
	localparam int SWD_AW   = (SWORDS > 1) ? $clog2(SWORDS) : 1;
	// reciprocal of the word size, exact for every 12-bit value
	localparam int DIV_MUL  = ((1 << DIV_SHIFT) + WORD_BITS - 1) / WORD_BITS;
	localparam int MUL_W    = DIV_SHIFT - 2;
	localparam int PROD_W   = VALUE_W + MUL_W;
	// bits past the last tracked value never count as holes
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		{WORD_BITS{1'b1}} >> (LEAVES * WORD_BITS - TRACKED);
	localparam logic [SUM_BITS-1:0] SUM_INIT =
		{SUM_BITS{1'b1}} >> (SUM_BITS - LEAVES);

	// control state
	mmt_state_t state_q, state_d;
	logic [CNT_AW-1:0]   clr_q;
	logic [SUM_BITS-1:0] sum_q;       // summary: 1 marks a leaf word that still has a hole
	logic                rvalid_q;

	// item context
	logic                op_q;
	logic [VALUE_W-1:0]  value_q;
	logic [LEAF_AW-1:0]  leaf_q;
	logic [BIT_AW-1:0]   bit_q;
	status_t             status_q;
	logic [MEX_W-1:0]    mex_q;
	logic [SUM_AW-1:0]   base_q;      // first flat summary bit of the word under scan
	logic [SWD_AW-1:0]   swd_q;
	logic [LEAF_AW-1:0]  lfa_q;       // leaf word picked by the summary scan
	logic [MEX_W-1:0]    rmex_q;
	status_t             rstatus_q;

	// ram ports
	logic                  cnt_we;
	logic [CNT_AW-1:0]     cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [CNT_AW-1:0]     cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic                  leaf_we;
	logic [LEAF_AW-1:0]    leaf_waddr;
	logic [WORD_BITS-1:0]  leaf_wdata;
	logic [LEAF_AW-1:0]    leaf_raddr;
	logic [WORD_BITS-1:0]  leaf_rd;

	// datapath
	logic                  oor;
	logic [PROD_W-1:0]     prod;
	logic [VALUE_W-1:0]    offset;
	logic [WORD_BITS-1:0]  bit_mask;
	logic                  cnt_zero;
	logic                  cnt_one;
	logic                  cnt_full;
	logic [WORD_BITS-1:0]  leaf_cleared;
	logic [WORD_BITS-1:0]  sum_word;
	logic [WORD_BITS-1:0]  ctz_in;
	logic [BIT_AW-1:0]     ctz_idx;
	logic                  ctz_any;
	logic [SUM_AW-1:0]     found_leaf;
	logic                  out_free;
	logic                  clr_last;

	mmt_ram #(.WIDTH(COUNT_BITS), .DEPTH(TRACKED)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rd)
	);

	mmt_ram #(.WIDTH(WORD_BITS), .DEPTH(LEAVES)) u_leaf_ram (
		.clk   (clk),
		.we    (leaf_we),
		.waddr (leaf_waddr),
		.wdata (leaf_wdata),
		.raddr (leaf_raddr),
		.rdata (leaf_rd)
	);

	// value split: leaf = value / WORD_BITS via reciprocal, bit = remainder taken in READ
	assign oor    = MEX_W'(value_q) >= MEX_W'(TRACKED);
	assign prod   = PROD_W'(value_q) * PROD_W'(DIV_MUL);
	assign offset = value_q - VALUE_W'(leaf_q) * VALUE_W'(WORD_BITS);

	// count and leaf tests while the read data is up
	assign bit_mask     = WORD_BITS'(1) << bit_q;
	assign cnt_zero     = cnt_rd == '0;
	assign cnt_one      = cnt_rd == COUNT_BITS'(1);
	assign cnt_full     = &cnt_rd;
	assign leaf_cleared = leaf_rd & ~bit_mask;

	// shared trailing-zero unit: summary word during the scan, leaf word afterwards
	assign sum_word = sum_q[base_q +: WORD_BITS];
	assign ctz_in   = (state_q == MMT_LEAF) ? leaf_rd : sum_word;
	assign ctz_any  = |ctz_in;

	always_comb begin
		ctz_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (ctz_in[i]) begin
				ctz_idx = BIT_AW'(i);
			end
		end
	end

	assign found_leaf = base_q + SUM_AW'(ctz_idx);
	assign out_free   = !rvalid_q || result.ready;
	assign clr_last   = clr_q == CNT_AW'(TRACKED - 1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MMT_CLEAR: begin
				if (clr_last) begin
					state_d = MMT_IDLE;
				end
			end
			MMT_IDLE: begin
				if (item.valid) begin
					state_d = MMT_DIV;
				end
			end
			MMT_DIV: begin
				state_d = oor ? MMT_SCAN : MMT_READ;
			end
			MMT_READ: begin
				state_d = MMT_MODIFY;
			end
			MMT_MODIFY: begin
				state_d = MMT_SCAN;
			end
			MMT_SCAN: begin
				if (ctz_any) begin
					state_d = MMT_LEAF;
				end else if (swd_q == SWD_AW'(SWORDS - 1)) begin
					state_d = MMT_DONE;
				end
			end
			MMT_LEAF: begin
				state_d = MMT_DONE;
			end
			MMT_DONE: begin
				if (out_free) begin
					state_d = MMT_IDLE;
				end
			end
			default: begin
				state_d = MMT_CLEAR;
			end
		endcase
	end

	// ram control and handshake outputs
	always_comb begin
		item.ready = 1'b0;
		cnt_we     = 1'b0;
		cnt_waddr  = value_q[CNT_AW-1:0];
		cnt_wdata  = '0;
		cnt_raddr  = value_q[CNT_AW-1:0];
		leaf_we    = 1'b0;
		leaf_waddr = leaf_q;
		leaf_wdata = leaf_rd;
		leaf_raddr = leaf_q;
		unique case (state_q)
			MMT_CLEAR: begin
				// one count entry and, while in range, one leaf word per cycle
				cnt_we     = 1'b1;
				cnt_waddr  = clr_q;
				leaf_we    = clr_q < CNT_AW'(LEAVES);
				leaf_waddr = clr_q[LEAF_AW-1:0];
				leaf_wdata = (clr_q == CNT_AW'(LEAVES - 1)) ? LAST_MASK : '1;
			end
			MMT_IDLE: begin
				item.ready = 1'b1;
			end
			MMT_MODIFY: begin
				if (op_q == OP_INSERT) begin
					cnt_we     = !cnt_full;
					cnt_wdata  = cnt_rd + COUNT_BITS'(1);
					leaf_we    = !cnt_full && cnt_zero;
					leaf_wdata = leaf_cleared;
				end else begin
					cnt_we     = !cnt_zero;
					cnt_wdata  = cnt_rd - COUNT_BITS'(1);
					leaf_we    = cnt_one;
					leaf_wdata = leaf_rd | bit_mask;
				end
			end
			MMT_SCAN: begin
				leaf_raddr = found_leaf[LEAF_AW-1:0];
			end
			MMT_LEAF: begin
				leaf_raddr = lfa_q;
			end
			MMT_DIV, MMT_READ, MMT_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= MMT_CLEAR;
			clr_q    <= '0;
			sum_q    <= SUM_INIT;
			rvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == MMT_CLEAR) begin
				clr_q <= clr_q + CNT_AW'(1);
			end
			// summary follows the leaf: clear when a word fills, set when a full word gains a hole
			if (state_q == MMT_MODIFY) begin
				if (op_q == OP_INSERT) begin
					if (!cnt_full && cnt_zero && leaf_cleared == '0) begin
						sum_q[leaf_q] <= 1'b0;
					end
				end else if (cnt_one && leaf_rd == '0) begin
					sum_q[leaf_q] <= 1'b1;
				end
			end
			if (state_q == MMT_DONE && out_free) begin
				rvalid_q <= 1'b1;
			end else if (result.ready) begin
				rvalid_q <= 1'b0;
			end
		end
	end

	// item context and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			MMT_IDLE: begin
				op_q    <= item.operation;
				value_q <= item.value;
			end
			MMT_DIV: begin
				leaf_q   <= prod[DIV_SHIFT +: LEAF_AW];
				base_q   <= '0;
				swd_q    <= '0;
				mex_q    <= MEX_W'(TRACKED);
				status_q <= (op_q == OP_ERASE) ? ST_ABSENT : ST_CEILING;
			end
			MMT_READ: begin
				bit_q <= offset[BIT_AW-1:0];
			end
			MMT_MODIFY: begin
				if (op_q == OP_INSERT) begin
					status_q <= cnt_full ? ST_CEILING : ST_APPLIED;
				end else begin
					status_q <= cnt_zero ? ST_ABSENT : ST_APPLIED;
				end
			end
			MMT_SCAN: begin
				lfa_q  <= found_leaf[LEAF_AW-1:0];
				base_q <= base_q + SUM_AW'(WORD_BITS);
				swd_q  <= swd_q + SWD_AW'(1);
			end
			MMT_LEAF: begin
				if (ctz_any) begin
					mex_q <= MEX_W'(lfa_q) * MEX_W'(WORD_BITS) + MEX_W'(ctz_idx);
				end
			end
			MMT_DONE: begin
				if (out_free) begin
					rmex_q    <= mex_q;
					rstatus_q <= status_q;
				end
			end
			MMT_CLEAR: begin
			end
			default: begin
			end
		endcase
	end

	// result output register: holds until the transfer completes
	assign result.valid  = rvalid_q;
	assign result.mex    = rmex_q;
	assign result.status = rstatus_q;

endmodule

// ----- rtl/mmt_checker.sv -----
// mmt_checker: port-level assertions for multiset_mex_tracker, bound to the top level
// depends on mmt_pkg and multiset_mex_tracker

module mmt_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_ready,
	input logic                  result_valid,
	input logic                  result_ready,
	input logic [mmt_pkg::MEX_W-1:0] result_mex,
	input mmt_pkg::status_t      result_status
);
	import mmt_pkg::*;

	// a stalled result keeps its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_mex)
			&& $stable(result_status))
		else $error("stalled result changed");

	// one item at a time: no second transfer right after one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input taken while busy");

	// the mex never exceeds VALUE_SPAN, one past the largest value
	a_mex_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_mex <= MEX_W'(VALUE_SPAN))
		else $error("mex out of range");

	// only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_status == ST_APPLIED || result_status == ST_ABSENT
			|| result_status == ST_CEILING)
		else $error("undefined status code");

	// a result never rises straight after its input transfer
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !$rose(result_valid))
		else $error("result too early");

endmodule

bind multiset_mex_tracker mmt_checker u_mmt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.result_mex    (result.mex),
	.result_status (result.status)
);

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for multiset_mex_tracker; insert and erase transfers are
// checked against a behavioral copy of the count store and the two-level absent bitmap
// depends on mmt_pkg, mmt_item_if, mmt_result_if and the tracker rtl

module tb_top;
	import mmt_pkg::*;

	// block configuration under test
	localparam int CAPACITY   = 4096;
	localparam int WORD_BITS  = 64;
	localparam int COUNT_BITS = 16;
	localparam int LEAF_WORDS = CAPACITY / WORD_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_CEIL = '1;

	// run control
	localparam int STALL_LIMIT  = 20000;	// covers the clearing pass after reset
	localparam int DRAIN_CYCLES = 64;
	localparam int MAX_REPORTS  = 40;
	localparam int RANDOM_ITEMS = 1030;
	localparam int FILL_SPAN    = 3 * WORD_BITS;	// low values filled completely
	localparam int COUNT_RUN    = 40;

	typedef struct packed {
		logic [MEX_W-1:0] mex;
		status_t          status;
	} mex_result_t;

	logic clk;
	logic arst_n;

	mmt_item_if   item_ch ();
	mmt_result_if result_ch ();

	multiset_mex_tracker #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS),
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch.sink),
		.result(result_ch.source)
	);

	// shadow of the multiset: per-value counts, absent-value leaves, leaves-with-hole summary
	logic [COUNT_BITS-1:0] occ_count [CAPACITY];
	logic [WORD_BITS-1:0]  absent_leaf [LEAF_WORDS];
	logic [WORD_BITS-1:0]  hole_summary;

	// mex/status pairs owed by the block, oldest first
	mex_result_t pending_mex [$];

	int error_count = 0;
	int idle_cycles = 0;
	int burst_left  = 0;
	bit sender_gaps;
	bit receiver_stalls;
	int value_order [CAPACITY];

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	function automatic int lowest_set(logic [WORD_BITS-1:0] w);
		for (int n = 0; n < WORD_BITS; n++)
			if (w[n]) return n;
		return 0;
	endfunction

	// two-level descent: first leaf with a hole, then first hole in that leaf
	function automatic logic [MEX_W-1:0] current_mex();
		int leaf;
		if (hole_summary == '0) return MEX_W'(CAPACITY);
		leaf = lowest_set(hole_summary);
		if (absent_leaf[leaf] == '0) return MEX_W'(CAPACITY);
		return MEX_W'(leaf * WORD_BITS + lowest_set(absent_leaf[leaf]));
	endfunction

	// applies one insert or erase to the shadow and returns the mex and status it yields
	function automatic mex_result_t apply_update(logic op, logic [VALUE_W-1:0] v);
		mex_result_t r;
		int leaf;
		int bitpos;
		leaf     = v / WORD_BITS;
		bitpos   = v % WORD_BITS;
		r.status = ST_APPLIED;
		if (op == OP_INSERT) begin
			if (occ_count[v] == COUNT_CEIL) begin
				r.status = ST_CEILING;
			end else begin
				// first occurrence fills the hole; a leaf with no hole left drops from the summary
				if (occ_count[v] == '0) begin
					absent_leaf[leaf][bitpos] = 1'b0;
					if (absent_leaf[leaf] == '0) hole_summary[leaf] = 1'b0;
				end
				occ_count[v] = occ_count[v] + 1'b1;
			end
		end else if (occ_count[v] == '0) begin
			r.status = ST_ABSENT;
		end else begin
			// last occurrence gone: a full leaf that gains a hole comes back into the summary
			if (occ_count[v] == 1) begin
				if (absent_leaf[leaf] == '0) hole_summary[leaf] = 1'b1;
				absent_leaf[leaf][bitpos] = 1'b1;
			end
			occ_count[v] = occ_count[v] - 1'b1;
		end
		r.mex = current_mex();
		return r;
	endfunction

	function automatic void note_mismatch(string field, int expected_v, int actual_v);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, field, expected_v, actual_v);
	endfunction

	// ------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------

	// bursts of back-to-back transfers separated by random gaps
	task automatic pace_sender();
		int gap;
		if (!sender_gaps) return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 24);
		gap = $urandom_range(1, 12);
		item_ch.valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	// presents one item and holds it until the transfer; called at a rising edge
	task automatic send_item(input logic op, input logic [VALUE_W-1:0] v);
		item_ch.valid     <= 1'b1;
		item_ch.operation <= op;
		item_ch.value     <= v;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		pending_mex.push_back(apply_update(op, v));
		pace_sender();
	endtask

	// drops valid and lets every owed result come back; always waits on the clock before it checks
	task automatic wait_all_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_mex.size() != 0);
	endtask

	task automatic shuffle_values();
		int pick;
		int tmp;
		for (int i = 0; i < CAPACITY; i++) value_order[i] = i;
		for (int i = CAPACITY - 1; i > 0; i--) begin
			pick = $urandom_range(0, i);
			tmp = value_order[i];
			value_order[i] = value_order[pick];
			value_order[pick] = tmp;
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// edges of the value field, both operations, erase of an absent value, word boundaries
	task automatic test_directed();
		send_item(OP_INSERT, 12'd0);
		send_item(OP_INSERT, 12'd0);
		send_item(OP_ERASE,  12'd5);
		send_item(OP_ERASE,  12'd0);
		send_item(OP_ERASE,  12'd0);
		send_item(OP_ERASE,  12'd0);
		send_item(OP_INSERT, 12'd4095);
		send_item(OP_INSERT, 12'hAAA);
		send_item(OP_INSERT, 12'h555);
		send_item(OP_ERASE,  12'd4095);
		send_item(OP_ERASE,  12'hAAA);
		send_item(OP_ERASE,  12'h555);
		send_item(OP_ERASE,  12'd4095);
		send_item(OP_INSERT, 12'd1);
		send_item(OP_INSERT, 12'd0);
		send_item(OP_INSERT, 12'd63);
		send_item(OP_INSERT, 12'd64);
		send_item(OP_INSERT, 12'd2);
		send_item(OP_ERASE,  12'd1);
		send_item(OP_ERASE,  12'd0);
		send_item(OP_ERASE,  12'd63);
		send_item(OP_ERASE,  12'd64);
		send_item(OP_ERASE,  12'd2);
	endtask

	// fill the low leaves in random order so the mex climbs past whole words, punch holes
	// into full leaves, then empty the multiset again
	task automatic test_fill_all();
		int v;
		int w;
		shuffle_values();
		for (int i = 0; i < CAPACITY; i++)
			if (value_order[i] < FILL_SPAN) send_item(OP_INSERT, VALUE_W'(value_order[i]));
		for (int k = 0; k < 8; k++) begin
			v = $urandom_range(0, FILL_SPAN - 1);
			w = (v / WORD_BITS) * WORD_BITS + $urandom_range(0, WORD_BITS - 1);
			while (occ_count[v] != '0) send_item(OP_ERASE, VALUE_W'(v));
			while (occ_count[w] != '0) send_item(OP_ERASE, VALUE_W'(w));
			send_item(OP_INSERT, VALUE_W'(w));
			send_item(OP_INSERT, VALUE_W'(v));
		end
		shuffle_values();
		for (int i = 0; i < CAPACITY; i++)
			while (occ_count[value_order[i]] != '0)
				send_item(OP_ERASE, VALUE_W'(value_order[i]));
	endtask

	// stack many occurrences of one value at full rate, then erase one past empty
	task automatic test_count_run();
		logic [VALUE_W-1:0] v;
		wait_all_results();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		v = VALUE_W'($urandom_range(0, CAPACITY - 1));
		repeat (COUNT_RUN) send_item(OP_INSERT, v);
		repeat (COUNT_RUN + 1) send_item(OP_ERASE, v);
		wait_all_results();
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	// mostly small values so the mex keeps moving, a few across the full range;
	// idling and stalls are redrawn every 250 transfers
	task automatic test_random_mix();
		int window;
		logic op;
		logic [VALUE_W-1:0] v;
		window = 63;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 250 == 0) begin
				case ($urandom_range(0, 3))
					0: window = 15;
					1: window = 63;
					2: window = 191;
					default: window = 511;
				endcase
				sender_gaps     = ($urandom_range(0, 3) != 0);
				receiver_stalls = ($urandom_range(0, 3) != 0);
			end
			// halfway through, the sender holds off until the block has nothing in flight
			if (n == RANDOM_ITEMS / 2) wait_all_results();
			op = ($urandom_range(0, 99) < 56) ? OP_INSERT : OP_ERASE;
			if ($urandom_range(0, 9) == 0) v = VALUE_W'($urandom);
			else v = VALUE_W'($urandom_range(0, window));
			send_item(op, v);
		end
	endtask

	// ------------------------------------------------------------------
	// receiver, checker, watchdog
	// ------------------------------------------------------------------

	// ready follows a random 32-bit pattern, sometimes solid high
	initial begin : receiver
		logic [31:0] ready_pattern;
		int phase;
		result_ch.ready <= 1'b0;
		ready_pattern = '1;
		phase = 0;
		forever begin
			@(posedge clk);
			if (phase == 0)
				ready_pattern = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | $urandom);
			result_ch.ready <= !receiver_stalls || ready_pattern[phase];
			phase = (phase + 1) % 32;
		end
	end

	// every result transfer is compared with the oldest owed pair
	always @(posedge clk) begin : check_results
		mex_result_t want;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_mex.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: result with nothing expected, actual mex %0d status %0d",
						$time, result_ch.mex, result_ch.status);
			end else begin
				want = pending_mex.pop_front();
				if (result_ch.mex !== want.mex)
					note_mismatch("mex", int'(want.mex), int'(result_ch.mex));
				if (result_ch.status !== want.status)
					note_mismatch("status", int'(want.status), int'(result_ch.status));
			end
		end
	end

	// ends the run when neither channel has moved for too long
	always @(posedge clk) begin
		if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
			(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results owed",
				$time, STALL_LIMIT, pending_mex.size());
			$display("FAIL multiset_mex_tracker");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.operation <= OP_INSERT;
		item_ch.value     <= '0;
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
		// shadow starts empty: no counts, every value absent, every leaf has a hole
		for (int i = 0; i < CAPACITY; i++) occ_count[i] = '0;
		for (int i = 0; i < LEAF_WORDS; i++) absent_leaf[i] = '1;
		hole_summary = '0;
		for (int i = 0; i < LEAF_WORDS; i++) hole_summary[i] = 1'b1;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_all();
		test_count_run();
		test_random_mix();

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS multiset_mex_tracker");
		else
			$display("FAIL multiset_mex_tracker");
		$finish;
	end

endmodule
